@@ hdl/dls_pkg.sv @@
package dls_pkg;

   // Width of the saturating lane accumulators.
   localparam int ACC_BITS = 40;
   // Number of lanes that have a weight field on the input channel.
   localparam int WEIGHT_FIELDS = 4;
   // Register and result field widths.
   localparam int CNT_W = 3;
   localparam int IDX_W = 2;
   localparam int ACT_W = 16;
   // Finished vectors that may wait between the accumulators and the output side.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] EXP_NEG1_Q30 = 64'd395007542;
   localparam logic [ACT_W-1:0] ACT_MAX = '1;

   // How a lane sum maps onto the sigmoid curve.
   typedef enum logic [1:0] {
      SIG_LOW    = 2'd0,
      SIG_HIGH   = 2'd1,
      SIG_LOOKUP = 2'd2
   } sig_code_type;

   // Restoring long division, used only while the table is built at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      int          i;
      q = '0;
      r = '0;
      for (i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // e to the power -t, with t and the result in unsigned Q30.
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] acc;
      logic [63:0] term;
      int          k;
      int          i;
      n    = t >> 30;
      f    = t & (Q30_ONE - 64'd1);
      acc  = Q30_ONE;
      term = Q30_ONE;
      for (k = 1; k <= 24; k++) begin
         term = udiv64((term * f) >> 30, 64'(k));
         if ((k % 2) == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      for (i = 0; i < 16; i++) begin
         if (64'(i) < n) begin
            acc = (acc * EXP_NEG1_Q30 + (Q30_ONE >> 1)) >> 30;
         end
      end
      return acc;
   endfunction

   // Sigmoid at the centre of bin idx out of size bins spread over [-8, 8).
   function automatic logic [ACT_W-1:0] sig_entry(input int idx, input int size);
      logic signed [63:0] xq;
      logic [63:0]        t;
      logic [63:0]        e;
      logic [63:0]        num;
      logic [63:0]        den;
      logic [63:0]        v;
      xq  = signed'(udiv64(64'(2 * idx + 1) << 33, 64'(size))) - (64'sd1 <<< 33);
      t   = (xq >= 0) ? 64'(xq) : 64'(-xq);
      e   = exp_neg_q30(t);
      num = (xq >= 0) ? Q30_ONE : e;
      den = Q30_ONE + e;
      v   = udiv64(num * 64'd65536 + (den >> 1), den);
      return (v > 64'(ACT_MAX)) ? ACT_MAX : v[ACT_W-1:0];
   endfunction

endpackage

@@ hdl/dls_queue.sv @@
module dls_queue import dls_pkg::*; #(
   parameter int WIDTH = 160
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0]  entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // The front never pushes into a full queue: it holds a credit for every vector in flight.
   always_comb begin
      wr_ptr_in = push ? QPTR_W'((32'(wr_ptr_ff) + 1) % QDEPTH) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'((32'(rd_ptr_ff) + 1) % QDEPTH) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

@@ hdl/dls_front.sv @@
module dls_front import dls_pkg::*; #(
   parameter int NL = 4,
   parameter int DATA_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DATA_BITS-1:0] x_value,
   input  logic signed [DATA_BITS-1:0] w_lane [WEIGHT_FIELDS],
   input  logic                        last_in,
   input  logic                        pop,
   output logic                        push,
   output logic [NL*ACC_BITS-1:0]      push_data
);

   localparam int PROD_W = 2 * DATA_BITS;
   localparam int SUM_W  = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
   localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_BITS - 1)) - 1);
   localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

   logic                        accept;
   logic [QCNT_W-1:0]           credit_ff, credit_in;
   logic                        s1_valid_ff;
   logic                        s1_last_ff;
   logic signed [PROD_W-1:0]    prod_ff [NL];
   logic signed [ACC_BITS-1:0]  acc_ff [NL];
   logic signed [ACC_BITS-1:0]  acc_in [NL];
   logic signed [ACC_BITS-1:0]  sat_sum [NL];
   logic signed [SUM_W-1:0]     raw_sum [NL];

   // A credit is taken for each accepted last item and returned when its vector leaves the queue.
   assign req_stall = (credit_ff == QCNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;
   assign credit_in = credit_ff + QCNT_W'(accept && last_in) - QCNT_W'(pop);

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         raw_sum[k] = SUM_W'(acc_ff[k]) + SUM_W'(prod_ff[k]);
         if (raw_sum[k] > ACC_MAX) begin
            sat_sum[k] = ACC_MAX[ACC_BITS-1:0];
         end else if (raw_sum[k] < ACC_MIN) begin
            sat_sum[k] = ACC_MIN[ACC_BITS-1:0];
         end else begin
            sat_sum[k] = raw_sum[k][ACC_BITS-1:0];
         end
         acc_in[k] = acc_ff[k];
         if (s1_valid_ff) begin
            acc_in[k] = s1_last_ff ? '0 : sat_sum[k];
         end
         push_data[k*ACC_BITS +: ACC_BITS] = sat_sum[k];
      end
   end

   assign push = s1_valid_ff && s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         for (int k = 0; k < NL; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= accept;
         s1_last_ff  <= accept && last_in;
         for (int k = 0; k < NL; k++) begin
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < NL; k++) begin
            prod_ff[k] <= PROD_W'(x_value) * PROD_W'(w_lane[k]);
         end
      end
   end

endmodule

@@ hdl/dls_back.sv @@
module dls_back import dls_pkg::*; #(
   parameter int NL = 4,
   parameter int DATA_BITS = 16,
   parameter int SIG_TABLE_SIZE = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CNT_W-1:0]       out_count,
   input  logic                   head_valid,
   input  logic [NL*ACC_BITS-1:0] head_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [IDX_W-1:0]       rsp_out_index,
   output logic [ACT_W-1:0]       rsp_activation,
   output logic                   rsp_last_out
);

   localparam int PROD_FRAC = 2 * (DATA_BITS - 4);
   localparam int U_W       = PROD_FRAC + 4;
   localparam int CMP_W     = ((ACC_BITS > U_W) ? ACC_BITS : U_W) + 2;
   localparam int PRE       = (U_W > 28) ? U_W - 28 : 0;
   localparam int UP_W      = U_W - PRE;
   localparam int TW        = (SIG_TABLE_SIZE > 1) ? $clog2(SIG_TABLE_SIZE) : 1;
   localparam int SZ_W      = $clog2(SIG_TABLE_SIZE + 1);
   localparam int MUL_W     = UP_W + SZ_W;
   localparam int KW        = (NL > 1) ? $clog2(NL) : 1;
   localparam logic signed [CMP_W-1:0] RANGE = CMP_W'(1) <<< (PROD_FRAC + 3);
   localparam logic [MUL_W-1:0] IDX_TOP = MUL_W'(SIG_TABLE_SIZE - 1);

   logic [ACT_W-1:0]         sig_rom [SIG_TABLE_SIZE];

   genvar g;
   for (g = 0; g < SIG_TABLE_SIZE; g++) begin : g_rom
      localparam logic [ACT_W-1:0] ENT = sig_entry(g, SIG_TABLE_SIZE);
      assign sig_rom[g] = ENT;
   end

   logic                     advance;
   logic [CNT_W-1:0]         n_out;
   logic [KW-1:0]            lane_ff, lane_in;
   logic                     issue;
   logic                     final_lane;
   logic signed [ACC_BITS-1:0] sel_sum;
   logic signed [CMP_W-1:0]  sum_ext;
   logic [CMP_W-1:0]         shifted;
   logic [UP_W-1:0]          u_pre;
   logic [MUL_W-1:0]         scaled;
   logic [MUL_W-1:0]         idx_full;
   sig_code_type             code_in;

   logic                     a_valid_ff;
   logic [IDX_W-1:0]         a_lane_ff;
   logic                     a_last_ff;
   sig_code_type             a_code_ff;
   logic [TW-1:0]            a_idx_ff;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_out_index_ff;
   logic [ACT_W-1:0]         rsp_activation_ff;
   logic                     rsp_last_out_ff;
   logic [ACT_W-1:0]         act_in;

   // The whole output side moves together whenever the output register is free or being taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign n_out   = (out_count > CNT_W'(NL)) ? CNT_W'(NL) : out_count;

   // Unless stalled, one head lane issues per cycle; the vector leaves after its final lane.
   always_comb begin
      final_lane = (CNT_W'(lane_ff) == n_out - CNT_W'(1));
      issue      = advance && head_valid && (n_out != '0);
      pop        = advance && head_valid && ((n_out == '0) || final_lane);
      lane_in    = lane_ff;
      if (pop) begin
         lane_in = '0;
      end else if (issue) begin
         lane_in = lane_ff + KW'(1);
      end
   end

   always_comb begin
      sel_sum  = head_data[lane_ff*ACC_BITS +: ACC_BITS];
      sum_ext  = CMP_W'(sel_sum);
      shifted  = CMP_W'(sum_ext + RANGE);
      u_pre    = UP_W'(shifted[U_W-1:0] >> PRE);
      scaled   = MUL_W'(u_pre) * MUL_W'(SIG_TABLE_SIZE);
      idx_full = scaled >> UP_W;
      if (idx_full > IDX_TOP) begin
         idx_full = IDX_TOP;
      end
      priority if (sum_ext < -RANGE) begin
         code_in = SIG_LOW;
      end else if (sum_ext >= RANGE) begin
         code_in = SIG_HIGH;
      end else begin
         code_in = SIG_LOOKUP;
      end
   end

   always_comb begin
      unique case (a_code_ff)
         SIG_LOW:    act_in = '0;
         SIG_HIGH:   act_in = ACT_MAX;
         SIG_LOOKUP: act_in = sig_rom[a_idx_ff];
         default:    act_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff      <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lane_ff <= lane_in;
         if (advance) begin
            a_valid_ff   <= issue;
            rsp_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_lane_ff         <= IDX_W'(lane_ff);
         a_last_ff         <= final_lane;
         a_code_ff         <= code_in;
         a_idx_ff          <= idx_full[TW-1:0];
         rsp_out_index_ff  <= a_lane_ff;
         rsp_activation_ff <= act_in;
         rsp_last_out_ff   <= a_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_out_index_ff;
   assign rsp_activation = rsp_activation_ff;
   assign rsp_last_out   = rsp_last_out_ff;

endmodule

@@ hdl/dense_layer_sigmoid_core.sv @@
// Streams one input element and its per-lane weights per item, one item every cycle, with no
// pause between vectors: each lane multiplies in one stage and accumulates into a saturating
// 40-bit sum in the next. On an item marked last, the finished sums move into a four-vector queue
// and the accumulators clear. The output side then gives one activation per active lane, one a
// cycle unless the output stalls; from the head of the queue each result passes through a lookup
// register and then the output register. Input stalls only when four finished vectors are still
// waiting to be sent. A count of zero clears the sums and sends nothing.
module dense_layer_sigmoid_core import dls_pkg::*; #(
   parameter int LANES = 4,
   parameter int SIG_TABLE_SIZE = 256,
   parameter int DATA_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [CNT_W-1:0]            csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DATA_BITS-1:0] req_x_value,
   input  logic signed [DATA_BITS-1:0] req_w_lane0,
   input  logic signed [DATA_BITS-1:0] req_w_lane1,
   input  logic signed [DATA_BITS-1:0] req_w_lane2,
   input  logic signed [DATA_BITS-1:0] req_w_lane3,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [IDX_W-1:0]            rsp_out_index,
   output logic [ACT_W-1:0]            rsp_activation,
   output logic                        rsp_last_out
);

   // Lanes beyond the weight fields are not built and can never send a result.
   localparam int NL = (LANES < WEIGHT_FIELDS) ? LANES : WEIGHT_FIELDS;

   logic [CNT_W-1:0]            out_count_ff;
   logic signed [DATA_BITS-1:0] w_all [WEIGHT_FIELDS];
   logic                        push;
   logic [NL*ACC_BITS-1:0]      push_data;
   logic                        pop;
   logic                        head_valid;
   logic [NL*ACC_BITS-1:0]      head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff <= CNT_W'(4);
      end else if (csr_write_en) begin
         out_count_ff <= csr_write_data;
      end
   end

   assign w_all[0] = req_w_lane0;
   assign w_all[1] = req_w_lane1;
   assign w_all[2] = req_w_lane2;
   assign w_all[3] = req_w_lane3;

   dls_front #(
      .NL        (NL),
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .x_value   (req_x_value),
      .w_lane    (w_all),
      .last_in   (req_last_in),
      .pop       (pop),
      .push      (push),
      .push_data (push_data)
   );

   dls_queue #(
      .WIDTH (NL * ACC_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   dls_back #(
      .NL             (NL),
      .DATA_BITS      (DATA_BITS),
      .SIG_TABLE_SIZE (SIG_TABLE_SIZE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .out_count      (out_count_ff),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_index  (rsp_out_index),
      .rsp_activation (rsp_activation),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

@@ test/dense_layer_sigmoid_core_tb.sv @@
`timescale 1ns / 1ps

module dense_layer_sigmoid_core_tb import dls_pkg::*;;

   localparam int DATA_BITS = 16;
   localparam int TABLE_SIZE = 256;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES = 80;
   localparam int DIR_ROWS = 9;
   localparam longint RUN_LIMIT_NS = 1_000_000;

   typedef longint unsigned u64_type;

   localparam u64_type ONE_Q30 = 64'd1 << 30;
   localparam u64_type E_INV_Q30 = 64'd395007542;
   localparam longint SIG_SPAN = 64'sd1 <<< 27;
   localparam longint ACC_TOP = (64'sd1 <<< (ACC_BITS - 1)) - 1;
   localparam longint ACC_BOTTOM = -ACC_TOP - 1;

   typedef struct packed {
      logic [DATA_BITS-1:0]                        x;
      logic [0:WEIGHT_FIELDS-1][DATA_BITS-1:0]     w;
      logic                                        last;
   } elem_type;

   // A directed row may give some activations by hand; the rest come from the lane model.
   typedef struct packed {
      elem_type                               item;
      logic [0:WEIGHT_FIELDS-1]               typed;
      logic [0:WEIGHT_FIELDS-1][ACT_W-1:0]    given;
   } dir_row_type;

   typedef struct packed {
      logic [IDX_W-1:0] lane;
      logic [ACT_W-1:0] act;
      logic             last;
   } act_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CNT_W-1:0]     csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DATA_BITS-1:0] req_x_value = '0;
   logic [DATA_BITS-1:0] req_w_lane0 = '0;
   logic [DATA_BITS-1:0] req_w_lane1 = '0;
   logic [DATA_BITS-1:0] req_w_lane2 = '0;
   logic [DATA_BITS-1:0] req_w_lane3 = '0;
   logic                 req_last_in = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [IDX_W-1:0]     rsp_out_index;
   logic [ACT_W-1:0]     rsp_activation;
   logic                 rsp_last_out;

   logic                 hold_rsp = 1'b0;
   logic                 hold_go = 1'b0;
   logic                 idle_on = 1'b0;
   int                   rsp_burst = 0;

   logic [ACT_W-1:0]            sig_curve [TABLE_SIZE];
   logic signed [ACC_BITS-1:0]  lane_acc [WEIGHT_FIELDS];
   logic [CNT_W-1:0]            cfg_count = 3'd4;
   act_type                     pending_acts [$];
   dir_row_type                 dir_rows [DIR_ROWS];

   int mismatches = 0;
   int results_checked = 0;
   int vectors_done = 0;
   int silent_vectors = 0;
   int input_stalls = 0;

   dense_layer_sigmoid_core DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_value    (req_x_value),
      .req_w_lane0    (req_w_lane0),
      .req_w_lane1    (req_w_lane1),
      .req_w_lane2    (req_w_lane2),
      .req_w_lane3    (req_w_lane3),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_index  (rsp_out_index),
      .rsp_activation (rsp_activation),
      .rsp_last_out   (rsp_last_out)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want_v);
      $display("mismatch at %0t ns: %s got %0d, wanted %0d", $time, what, got, want_v);
      mismatches++;
   endtask

   // e to the power -t, both in unsigned Q30, by a Taylor series on the fraction and one
   // multiply by 1/e per whole unit.
   function automatic u64_type exp_minus(input u64_type t);
      u64_type whole;
      u64_type frac;
      u64_type acc;
      u64_type term;
      int      k;
      int      i;
      whole = t >> 30;
      frac  = t & (ONE_Q30 - 1);
      acc   = ONE_Q30;
      term  = ONE_Q30;
      for (k = 1; k <= 24; k++) begin
         term = ((term * frac) >> 30) / u64_type'(k);
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      for (i = 0; i < whole && i < 16; i++) begin
         acc = (acc * E_INV_Q30 + (ONE_Q30 >> 1)) >> 30;
      end
      return acc;
   endfunction

   function automatic logic [ACT_W-1:0] curve_point(input int i);
      longint  xq;
      u64_type t;
      u64_type e;
      u64_type num;
      u64_type den;
      u64_type v;
      xq  = longint'((u64_type'(2 * i + 1) << 33) / u64_type'(TABLE_SIZE)) - (64'sd1 <<< 33);
      t   = (xq >= 0) ? u64_type'(xq) : u64_type'(-xq);
      e   = exp_minus(t);
      num = (xq >= 0) ? ONE_Q30 : e;
      den = ONE_Q30 + e;
      v   = (num * 65536 + den / 2) / den;
      return (v > 65535) ? 16'hFFFF : v[ACT_W-1:0];
   endfunction

   function automatic logic [ACT_W-1:0] sigmoid_of(input logic signed [ACC_BITS-1:0] sum);
      longint       s;
      sig_code_type zone;
      s = sum;
      if (s < -SIG_SPAN) begin
         zone = SIG_LOW;
      end else if (s >= SIG_SPAN) begin
         zone = SIG_HIGH;
      end else begin
         zone = SIG_LOOKUP;
      end
      case (zone)
         SIG_LOW: return '0;
         SIG_HIGH: return '1;
         default: return sig_curve[((s + SIG_SPAN) * TABLE_SIZE) >>> 28];
      endcase
   endfunction

   // Adds one element into every lane and, on the last element, queues the activations.
   function automatic void accumulate_elem(input elem_type e,
                                           input logic [0:WEIGHT_FIELDS-1] typed,
                                           input logic [0:WEIGHT_FIELDS-1][ACT_W-1:0] given);
      longint  s;
      int      k;
      int      n;
      act_type r;
      for (k = 0; k < WEIGHT_FIELDS; k++) begin
         s = longint'(lane_acc[k]) + longint'(signed'(e.x)) * longint'(signed'(e.w[k]));
         if (s > ACC_TOP) s = ACC_TOP;
         if (s < ACC_BOTTOM) s = ACC_BOTTOM;
         lane_acc[k] = s[ACC_BITS-1:0];
      end
      if (e.last) begin
         vectors_done++;
         n = (cfg_count > WEIGHT_FIELDS) ? WEIGHT_FIELDS : int'(cfg_count);
         if (n == 0) silent_vectors++;
         for (k = 0; k < n; k++) begin
            r.lane = IDX_W'(k);
            r.act  = typed[k] ? given[k] : sigmoid_of(lane_acc[k]);
            r.last = (k == n - 1);
            pending_acts.push_back(r);
         end
         for (k = 0; k < WEIGHT_FIELDS; k++) begin
            lane_acc[k] = '0;
         end
      end
   endfunction

   function automatic logic [DATA_BITS-1:0] rand_q12();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3, 4: return 16'($urandom);
         // Mostly small values, so that the sums land inside the table's range.
         default: return 16'($urandom_range(0, 12287) - 6144);
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the item was taken.
   task automatic send_elem(input elem_type e, input logic [0:WEIGHT_FIELDS-1] typed,
                            input logic [0:WEIGHT_FIELDS-1][ACT_W-1:0] given);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_value <= e.x;
      req_w_lane0 <= e.w[0];
      req_w_lane1 <= e.w[1];
      req_w_lane2 <= e.w[2];
      req_w_lane3 <= e.w[3];
      req_last_in <= e.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_elem(e, typed, given);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_acts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_out_count(input logic [CNT_W-1:0] v);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_count = v;
   endtask

   task automatic run_vectors(input int n_items);
      elem_type e;
      int       sent;
      int       len;
      int       j;
      int       k;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 6);
         for (j = 0; j < len; j++) begin
            e.x = rand_q12();
            for (k = 0; k < WEIGHT_FIELDS; k++) begin
               e.w[k] = rand_q12();
            end
            e.last = (j == len - 1);
            send_elem(e, '0, '0);
         end
         sent += len;
      end
   endtask

   // Single-item vectors offered while the output side is held off, so the queue fills.
   task automatic run_backpressure();
      elem_type e;
      int       j;
      int       k;
      idle_on = 1'b0;
      hold_go = 1'b1;
      for (j = 0; j < 12; j++) begin
         e.x = rand_q12();
         for (k = 0; k < WEIGHT_FIELDS; k++) begin
            e.w[k] = rand_q12();
         end
         e.last = 1'b1;
         send_elem(e, '0, '0);
      end
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin : result_check
      act_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_acts.size() == 0) begin
            report_mismatch("activation with none pending, lane", int'(rsp_out_index), -1);
         end else begin
            want = pending_acts.pop_front();
            if (rsp_out_index !== want.lane)
               report_mismatch("out_index", int'(rsp_out_index), int'(want.lane));
            if (rsp_activation !== want.act)
               report_mismatch("activation", int'(rsp_activation), int'(want.act));
            if (rsp_last_out !== want.last)
               report_mismatch("last_out", int'(rsp_last_out), int'(want.last));
            results_checked++;
         end
      end
      if (!reset && req_valid && req_stall) input_stalls++;
      if (rsp_burst != 0) begin
         rsp_burst--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_burst = $urandom_range(1, 15);
      end
      rsp_stall <= hold_rsp || (rsp_burst != 0);
   end

   initial begin : long_hold
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int i;
      for (i = 0; i < TABLE_SIZE; i++) begin
         sig_curve[i] = curve_point(i);
      end
      for (i = 0; i < WEIGHT_FIELDS; i++) begin
         lane_acc[i] = '0;
      end

      // Full-scale products, sums exactly on the table's edges and one step outside them.
      dir_rows[0] = '{'{16'h7FFF, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF}, 1'b1},
                      4'b1100, {16'hFFFF, 16'h0000, 16'h0000, 16'h0000}};
      dir_rows[1] = '{'{16'h8000, {16'h8000, 16'hF000, 16'h1000, 16'h7FFF}, 1'b1},
                      4'b1101, {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}};
      dir_rows[2] = '{'{16'h8000, {16'hF000, 16'h1000, 16'h0000, 16'h0000}, 1'b0},
                      4'b0000, '0};
      dir_rows[3] = '{'{16'h0001, {16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001}, 1'b1},
                      4'b0100, {16'h0000, 16'h0000, 16'h0000, 16'h0000}};
      dir_rows[4] = '{'{16'h0000, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1},
                      4'b0000, '0};
      dir_rows[5] = '{'{16'h1000, {16'h1000, 16'hF000, 16'h0800, 16'hF800}, 1'b0},
                      4'b0000, '0};
      dir_rows[6] = '{'{16'h5555, {16'hAAAA, 16'h5555, 16'h0123, 16'hFEDC}, 1'b0},
                      4'b0000, '0};
      dir_rows[7] = '{'{16'hAAAA, {16'hAAAA, 16'h5555, 16'h0040, 16'hFFC0}, 1'b1},
                      4'b0000, '0};
      dir_rows[8] = '{'{16'h0800, {16'h0800, 16'h0800, 16'hF800, 16'h0000}, 1'b1},
                      4'b0000, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      for (i = 0; i < DIR_ROWS; i++) begin
         send_elem(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].given);
      end

      set_out_count(3'd1);
      run_vectors(10);
      set_out_count(3'd0);
      run_vectors(8);
      set_out_count(3'd2);
      run_vectors(10);
      set_out_count(3'd7);
      run_vectors(8);
      run_backpressure();
      set_out_count(3'd3);
      run_vectors(10);
      set_out_count(3'd5);
      run_vectors(6);
      set_out_count(3'd6);
      run_vectors(6);

      // Closing stretch at full rate on both sides.
      idle_on = 1'b0;
      set_out_count(3'd4);
      run_vectors(14);
      wait_drained();

      $display("covered %0d vectors (%0d with no output) over output counts 0 to 7, %0d activations",
               vectors_done, silent_vectors, results_checked);
      $display("input held off for %0d cycles while the output side was blocked", input_stalls);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
